// ----- rtl/mono12_packed_frame_unpacker_macros.svh -----
// ----------------------------------------------------------------------------
// mono12_packed_frame_unpacker_macros
// Assertion macros used by the checker file of the unpacker.
// ----------------------------------------------------------------------------
`ifndef MONO12_PACKED_FRAME_UNPACKER_MACROS_SVH
`define MONO12_PACKED_FRAME_UNPACKER_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define M12U_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define M12U_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/m12u_pkg.sv -----
// ----------------------------------------------------------------------------
// m12u_pkg
// Types and constants shared by the Mono12Packed frame unpacker modules.
// ----------------------------------------------------------------------------
package m12u_pkg;

  localparam int unsigned PosW   = 25;
  localparam int unsigned LenW   = 24;
  localparam int unsigned DimW   = 13;
  localparam int unsigned StrW   = 16;
  localparam int unsigned PairW  = 15;
  localparam int unsigned PixW   = 12;
  localparam int unsigned FrameW = 16;
  localparam int unsigned StatW  = 2;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;
  localparam int unsigned TdataW = 72;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] RegFrameLength = 2'd0;
  localparam logic [1:0] RegImageWidth  = 2'd1;
  localparam logic [1:0] RegImageHeight = 2'd2;
  localparam logic [1:0] RegRowStride   = 2'd3;

  // Status codes.
  localparam logic [StatW-1:0] StatusOk       = 2'd0;
  localparam logic [StatW-1:0] StatusBadFrame = 2'd1;
  localparam logic [StatW-1:0] StatusBadTick  = 2'd2;

  // Result kinds.
  localparam logic KindPixel  = 1'b0;
  localparam logic KindStatus = 1'b1;

  // Block layout.
  localparam logic [31:0]     FrameId    = 32'd0;
  localparam logic [31:0]     TickId     = 32'd1;
  localparam logic [31:0]     TickLength = 32'd12;
  localparam logic [PosW-1:0] PosIdEnd   = 25'd3;
  localparam logic [PosW-1:0] PosLenEnd  = 25'd7;
  localparam logic [PosW-1:0] PosPixel   = 25'd8;
  localparam logic [3:0]      NibbleMask = 4'hF;

  // Offsets from L of the tail positions.
  localparam logic [PosW-1:0] OffPixEnd  = 25'd4;
  localparam logic [PosW-1:0] OffTickId  = 25'd7;
  localparam logic [PosW-1:0] OffTickLen = 25'd11;
  localparam logic [PosW-1:0] OffFinal   = 25'd19;

  // Byte phases within a 3-byte group.
  localparam logic [1:0] PhaseB0 = 2'd0;
  localparam logic [1:0] PhaseB1 = 2'd1;
  localparam logic [1:0] PhaseB2 = 2'd2;

  // Reset values of the registers.
  localparam logic [LenW-1:0] RstFrameLength = 24'd8;
  localparam logic [DimW-1:0] RstImageWidth  = 13'd2;
  localparam logic [DimW-1:0] RstImageHeight = 13'd1;
  localparam logic [StrW-1:0] RstRowStride   = 16'd3;

  typedef struct packed {
    logic [LenW-1:0]  frame_length;
    logic [DimW-1:0]  image_width;
    logic [DimW-1:0]  image_height;
    logic [StrW-1:0]  row_stride;
    logic [PosW-1:0]  pos_pix_end;
    logic [PosW-1:0]  pos_tick_id;
    logic [PosW-1:0]  pos_tick_len;
    logic [PosW-1:0]  pos_final;
    logic [DimW-1:0]  pairs_per_row;
  } cfg_t;

  typedef struct packed {
    logic              kind;
    logic [PixW-1:0]   pixel_even;
    logic [PixW-1:0]   pixel_odd;
    logic [PixW-1:0]   pixel_row;
    logic [PixW-1:0]   pixel_column;
    logic [FrameW-1:0] frame_index;
    logic [StatW-1:0]  status;
    logic              last;
  } result_t;

  function automatic logic [PosW-1:0] add_len(input logic [LenW-1:0] len,
                                              input logic [PosW-1:0] off);
    add_len = {1'b0, len} + off;
  endfunction

  function automatic logic [DimW-1:0] pairs_of(input logic [DimW-1:0] width);
    logic [DimW:0] sum;
    sum = {1'b0, width} + {{DimW{1'b0}}, 1'b1};
    pairs_of = sum[DimW:1];
  endfunction

endpackage

// ----- rtl/m12u_cfg.sv -----
// ----------------------------------------------------------------------------
// m12u_cfg
// APB register file with the tail positions derived at write time.
// ----------------------------------------------------------------------------
module m12u_cfg import m12u_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;
  logic wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[AddrW-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_length  <= RstFrameLength;
      cfg_q.image_width   <= RstImageWidth;
      cfg_q.image_height  <= RstImageHeight;
      cfg_q.row_stride    <= RstRowStride;
      cfg_q.pos_pix_end   <= add_len(RstFrameLength, OffPixEnd);
      cfg_q.pos_tick_id   <= add_len(RstFrameLength, OffTickId);
      cfg_q.pos_tick_len  <= add_len(RstFrameLength, OffTickLen);
      cfg_q.pos_final     <= add_len(RstFrameLength, OffFinal);
      cfg_q.pairs_per_row <= pairs_of(RstImageWidth);
    end else if (wr_en) begin
      case (reg_idx)
        RegFrameLength: begin
          cfg_q.frame_length <= pwdata[LenW-1:0];
          cfg_q.pos_pix_end  <= add_len(pwdata[LenW-1:0], OffPixEnd);
          cfg_q.pos_tick_id  <= add_len(pwdata[LenW-1:0], OffTickId);
          cfg_q.pos_tick_len <= add_len(pwdata[LenW-1:0], OffTickLen);
          cfg_q.pos_final    <= add_len(pwdata[LenW-1:0], OffFinal);
        end
        RegImageWidth: begin
          cfg_q.image_width   <= pwdata[DimW-1:0];
          cfg_q.pairs_per_row <= pairs_of(pwdata[DimW-1:0]);
        end
        RegImageHeight: begin
          cfg_q.image_height <= pwdata[DimW-1:0];
        end
        RegRowStride: begin
          cfg_q.row_stride <= pwdata[StrW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegFrameLength: prdata = {{(DataW-LenW){1'b0}}, cfg_q.frame_length};
      RegImageWidth:  prdata = {{(DataW-DimW){1'b0}}, cfg_q.image_width};
      RegImageHeight: prdata = {{(DataW-DimW){1'b0}}, cfg_q.image_height};
      RegRowStride:   prdata = {{(DataW-StrW){1'b0}}, cfg_q.row_stride};
      default:        prdata = '0;
    endcase
  end

endmodule

// ----- rtl/m12u_parse.sv -----
// ----------------------------------------------------------------------------
// m12u_parse
// Block parser: position and row state plus the single-pass result logic.
// ----------------------------------------------------------------------------
module m12u_parse import m12u_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  logic [PosW-1:0]   pos_q, pos_d;
  logic [31:0]       hdr_q, hdr_d;
  logic [DimW-1:0]   row_q, row_d;
  logic [StrW-1:0]   bir_q, bir_d;
  logic [1:0]        phase_q, phase_d;
  logic [PairW-1:0]  pair_q, pair_d;
  logic [7:0]        held0_q, held0_d;
  logic [7:0]        held1_q, held1_d;
  logic [StatW-1:0]  err_q, err_d;
  logic [FrameW-1:0] fc_q, fc_d;

  always_comb begin
    logic          in_pix;
    logic          active;
    logic          tick_bad;
    logic [StrW:0] bir_inc;

    hdr_d   = {byte_i, hdr_q[31:8]};
    pos_d   = pos_q;
    row_d   = row_q;
    bir_d   = bir_q;
    phase_d = phase_q;
    pair_d  = pair_q;
    held0_d = held0_q;
    held1_d = held1_q;
    err_d   = err_q;
    fc_d    = fc_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    // Header checks; the frame check always wins over the tick check.
    if (pos_q == PosIdEnd && hdr_d != FrameId) err_d = StatusBadFrame;
    if (pos_q == PosLenEnd && hdr_d != {8'd0, cfg_i.frame_length}) err_d = StatusBadFrame;
    tick_bad = (pos_q == cfg_i.pos_tick_id && hdr_d != TickId) ||
               (pos_q == cfg_i.pos_tick_len && hdr_d != TickLength);
    if (tick_bad && err_d == StatusOk) err_d = StatusBadTick;

    in_pix  = (pos_q >= PosPixel) && (pos_q < cfg_i.pos_pix_end);
    active  = (row_q < cfg_i.image_height) &&
              (pair_q < {{(PairW-DimW){1'b0}}, cfg_i.pairs_per_row}) &&
              (bir_q < cfg_i.row_stride);
    bir_inc = {1'b0, bir_q} + {{StrW{1'b0}}, 1'b1};

    if (in_pix) begin
      if (active) begin
        case (phase_q)
          PhaseB0: held0_d = byte_i;
          PhaseB1: held1_d = byte_i;
          default: begin
            if (err_d != StatusBadFrame) begin
              res_valid_o        = 1'b1;
              res_o.kind         = KindPixel;
              res_o.pixel_even   = {held0_q, held1_q[3:0] & NibbleMask};
              res_o.pixel_odd    = {byte_i, held1_q[7:4]};
              res_o.pixel_row    = row_q[PixW-1:0];
              res_o.pixel_column = {pair_q[PixW-2:0], 1'b0};
              res_o.frame_index  = fc_q;
            end
          end
        endcase
      end
      if (bir_inc >= {1'b0, cfg_i.row_stride}) begin
        bir_d   = '0;
        phase_d = PhaseB0;
        pair_d  = '0;
        if (row_q < cfg_i.image_height) row_d = row_q + 1'b1;
      end else begin
        bir_d = bir_inc[StrW-1:0];
        if (phase_q == PhaseB2) begin
          phase_d = PhaseB0;
          pair_d  = pair_q + 1'b1;
        end else begin
          phase_d = phase_q + 1'b1;
        end
      end
    end

    if (pos_q >= cfg_i.pos_final) begin
      res_valid_o       = 1'b1;
      res_o             = '0;
      res_o.kind        = KindStatus;
      res_o.frame_index = fc_q;
      res_o.status      = err_d;
      res_o.last        = 1'b1;
      fc_d    = fc_q + 1'b1;
      pos_d   = '0;
      row_d   = '0;
      bir_d   = '0;
      phase_d = PhaseB0;
      pair_d  = '0;
      err_d   = StatusOk;
    end else begin
      pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      hdr_q   <= '0;
      row_q   <= '0;
      bir_q   <= '0;
      phase_q <= PhaseB0;
      pair_q  <= '0;
      held0_q <= '0;
      held1_q <= '0;
      err_q   <= StatusOk;
      fc_q    <= '0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      hdr_q   <= hdr_d;
      row_q   <= row_d;
      bir_q   <= bir_d;
      phase_q <= phase_d;
      pair_q  <= pair_d;
      held0_q <= held0_d;
      held1_q <= held1_d;
      err_q   <= err_d;
      fc_q    <= fc_d;
    end
  end

endmodule

// ----- rtl/mono12_packed_frame_unpacker.sv -----
// ----------------------------------------------------------------------------
// mono12_packed_frame_unpacker
// Parses frame-plus-tick blocks byte by byte and unpacks Mono12Packed pairs.
// ----------------------------------------------------------------------------
// Channel   Dir  Width  Contents
// s_axis    in   8      one stream byte per beat
// m_axis    out  72+1   pixel pair or end-of-block status, tuser = kind
// apb       in   4/32   frame_length, image_width, image_height, row_stride
//
// One byte per cycle while the result register is not stalled: a beat waits in
// the input register, is parsed in a single pass and any result lands in the
// result register, which drives the output.
// Reset clears all parser state and loads the register defaults.
// A stalled result register stalls the parser and, through it, the input.
// ----------------------------------------------------------------------------
module mono12_packed_frame_unpacker import m12u_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] stream_byte
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [11:0] pixel_even, [23:12] pixel_odd, [35:24] pixel_row,
  // [47:36] pixel_column, [63:48] frame_index, [65:64] status, rest zero
  output logic [TdataW-1:0] m_axis_tdata,
  output logic              m_axis_tuser,   // [0] kind
  output logic              m_axis_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  cfg_t    cfg;
  logic    in_valid_q;
  logic [7:0] in_byte_q;
  logic    step;
  logic    res_valid;
  result_t res;
  logic    out_valid_q;
  result_t out_q;

  m12u_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The parser steps whenever a byte is held and the result register is free or being emptied.
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  m12u_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {6'd0, out_q.status, out_q.frame_index, out_q.pixel_column,
                          out_q.pixel_row, out_q.pixel_odd, out_q.pixel_even};

endmodule

// ----- rtl/m12u_checker.sv -----
// ----------------------------------------------------------------------------
// m12u_checker
// Port-level checks on the unpacker, bound to its top level.
// ----------------------------------------------------------------------------
`include "mono12_packed_frame_unpacker_macros.svh"

module m12u_checker import m12u_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [TdataW-1:0] m_axis_tdata,
  input  logic              m_axis_tuser,
  input  logic              m_axis_tlast,
  input  logic              pready
);

  // A waiting result keeps its contents.
  `M12U_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

  // Only the status beat closes a block, and only it carries a status.
  `M12U_ASSERT(a_last_is_status, m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser), "tlast does not match kind")
  `M12U_ASSERT(a_pair_no_status, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[65:64] == StatusOk, "pixel beat carries a status")

  // Pixel pairs always start on an even column.
  `M12U_ASSERT(a_even_column, m_axis_tvalid && !m_axis_tuser |-> !m_axis_tdata[36], "odd pair column")

  `M12U_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

endmodule

bind mono12_packed_frame_unpacker m12u_checker u_m12u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .pready        (pready)
);
